// ===== rtl/core/dcc_pkg.sv =====
// Shared types, constants and helper functions for the day count to calendar date block.
package dcc_pkg;

  localparam int unsigned OPW = 16;

  localparam logic [11:0] EPOCH_YEAR      = 12'd1978;
  localparam logic [1:0]  EPOCH_MOD4      = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100    = 7'd78;
  localparam logic [1:0]  EPOCH_CENT_MOD4 = 2'd3;
  localparam logic [6:0]  LAST_OF_CENTURY = 7'd99;

  localparam logic [15:0] DAYS_LEAP_YEAR   = 16'd366;
  localparam logic [15:0] DAYS_COMMON_YEAR = 16'd365;
  localparam logic [10:0] MAX_MINUTE_OF_DAY = 11'd1439;
  localparam logic [15:0] MINUTES_PER_HOUR  = 16'd60;
  localparam logic [5:0]  MAX_SECOND        = 6'd59;
  localparam logic [3:0]  LAST_MONTH        = 4'd11;
  localparam logic [3:0]  FEBRUARY          = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_SEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] day_count;
    logic [10:0] minute_of_day;
    logic [11:0] tick_of_minute;
  } stamp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  typedef struct packed {
    logic           lt;
    logic [OPW-1:0] diff;
  } sub_res_t;

  // Month length for a zero-based month index; February grows in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      FEBRUARY:                               len = leap ? 5'd29 : 5'd28;
      default:                                len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/dcc_sub.sv =====
// Shared compare and subtract unit used by every step of the sequencer.
module dcc_sub (
  input  logic [dcc_pkg::OPW-1:0] a,
  input  logic [dcc_pkg::OPW-1:0] b,
  output dcc_pkg::sub_res_t       res
);

  logic [dcc_pkg::OPW:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.lt   = wide[dcc_pkg::OPW];
  assign res.diff = wide[dcc_pkg::OPW-1:0];

endmodule

// ===== rtl/core/day_count_to_calendar_date.sv =====
// Day count to calendar date converter: top level with sequencer and output register.
//
// Usage:
//   A timestamp transaction enters on stamp/stamp_valid and is taken when
//   stamp_stall is low. stamp_stall stays high while a timestamp is being
//   converted. One date transaction per timestamp leaves on date/date_valid;
//   the receiver holds it with date_stall and the date stays put until taken.
//   Conversion steps: the load of the working registers, then year stepping,
//   month stepping, hour stepping, second stepping, and the write of the
//   output register, which waits while a stalled date still holds it. All
//   steps share one compare and subtract unit, one step per cycle, so the
//   year walk dominates the conversion time. A new timestamp is taken while
//   the last date still waits in the output register.
//   Reset (rst, synchronous) returns the sequencer to idle and drops date_valid.
//   Minutes above 1439 read as 23:59; seconds saturate at 59.
module day_count_to_calendar_date #(
  parameter int unsigned TICK_RATE = 50,
  parameter int unsigned DAY_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            stamp_valid,
  output logic            stamp_stall,
  input  dcc_pkg::stamp_t stamp,
  output logic            date_valid,
  input  logic            date_stall,
  output dcc_pkg::date_t  date
);

  localparam logic [15:0] DAY_MASK =
    (DAY_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << DAY_BITS) - 64'd1);
  localparam logic [dcc_pkg::OPW-1:0] TICK_STEP = dcc_pkg::OPW'(TICK_RATE);

  dcc_pkg::state_t   state, state_next;
  dcc_pkg::sub_res_t res;

  logic [dcc_pkg::OPW-1:0] op_a, op_b;
  logic [15:0] days;
  logic [10:0] mins;
  logic [11:0] ticks;
  logic [11:0] year;
  logic [1:0]  y_mod4;
  logic [6:0]  y_mod100;
  logic [1:0]  cent_mod4;
  logic [3:0]  mon;
  logic [4:0]  hour;
  logic [5:0]  sec;
  logic        leap;
  logic        out_free;
  logic        accept;

  assign leap     = (y_mod4 == 2'd0) && ((y_mod100 != 7'd0) || (cent_mod4 == 2'd0));
  assign out_free = !date_valid || !date_stall;
  assign accept   = stamp_valid && !stamp_stall;
  assign stamp_stall = (state != dcc_pkg::ST_IDLE);

  dcc_sub u_sub (
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  always_comb begin
    state_next = state;
    op_a       = '0;
    op_b       = '0;
    unique case (state)
      dcc_pkg::ST_IDLE: begin
        if (stamp_valid) state_next = dcc_pkg::ST_YEAR;
      end
      dcc_pkg::ST_YEAR: begin
        op_a = days;
        op_b = leap ? dcc_pkg::DAYS_LEAP_YEAR : dcc_pkg::DAYS_COMMON_YEAR;
        if (res.lt) state_next = dcc_pkg::ST_MONTH;
      end
      dcc_pkg::ST_MONTH: begin
        op_a = days;
        op_b = dcc_pkg::OPW'(dcc_pkg::month_len(mon, leap));
        if (res.lt || mon == dcc_pkg::LAST_MONTH) state_next = dcc_pkg::ST_HOUR;
      end
      dcc_pkg::ST_HOUR: begin
        op_a = dcc_pkg::OPW'(mins);
        op_b = dcc_pkg::MINUTES_PER_HOUR;
        if (res.lt) state_next = dcc_pkg::ST_SEC;
      end
      dcc_pkg::ST_SEC: begin
        op_a = dcc_pkg::OPW'(ticks);
        op_b = TICK_STEP;
        if (res.lt || sec == dcc_pkg::MAX_SECOND) state_next = dcc_pkg::ST_DONE;
      end
      dcc_pkg::ST_DONE: begin
        if (out_free) state_next = dcc_pkg::ST_IDLE;
      end
      default: state_next = dcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: load on accept, then advance one step per cycle.
  always_ff @(posedge clk) begin
    case (state)
      dcc_pkg::ST_IDLE: begin
        if (accept) begin
          days      <= stamp.day_count & DAY_MASK;
          mins      <= (stamp.minute_of_day > dcc_pkg::MAX_MINUTE_OF_DAY) ?
                       dcc_pkg::MAX_MINUTE_OF_DAY : stamp.minute_of_day;
          ticks     <= stamp.tick_of_minute;
          year      <= dcc_pkg::EPOCH_YEAR;
          y_mod4    <= dcc_pkg::EPOCH_MOD4;
          y_mod100  <= dcc_pkg::EPOCH_MOD100;
          cent_mod4 <= dcc_pkg::EPOCH_CENT_MOD4;
          mon       <= '0;
          hour      <= '0;
          sec       <= '0;
        end
      end
      dcc_pkg::ST_YEAR: begin
        if (!res.lt) begin
          days   <= res.diff;
          year   <= year + 12'd1;
          y_mod4 <= y_mod4 + 2'd1;
          if (y_mod100 == dcc_pkg::LAST_OF_CENTURY) begin
            y_mod100  <= '0;
            cent_mod4 <= cent_mod4 + 2'd1;
          end else begin
            y_mod100 <= y_mod100 + 7'd1;
          end
        end
      end
      dcc_pkg::ST_MONTH: begin
        if (!res.lt && mon != dcc_pkg::LAST_MONTH) begin
          days <= res.diff;
          mon  <= mon + 4'd1;
        end
      end
      dcc_pkg::ST_HOUR: begin
        if (!res.lt) begin
          mins <= res.diff[10:0];
          hour <= hour + 5'd1;
        end
      end
      dcc_pkg::ST_SEC: begin
        if (!res.lt && sec != dcc_pkg::MAX_SECOND) begin
          ticks <= res.diff[11:0];
          sec   <= sec + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: drop the date once taken, load a finished one when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      date_valid <= 1'b0;
    end else if (state == dcc_pkg::ST_DONE && out_free) begin
      date_valid <= 1'b1;
    end else if (!date_stall) begin
      date_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dcc_pkg::ST_DONE && out_free) begin
      date.year         <= year;
      date.month        <= mon + 4'd1;
      date.day_of_month <= days[4:0] + 5'd1;
      date.hour         <= hour;
      date.minute       <= mins[5:0];
      date.second       <= sec;
    end
  end

endmodule

// ===== rtl/core/dcc_checker.sv =====
// Port-level checks for the day count to calendar date block, bound to the top level.
module dcc_checker (
  input logic            clk,
  input logic            rst,
  input logic            stamp_valid,
  input logic            stamp_stall,
  input dcc_pkg::stamp_t stamp,
  input logic            date_valid,
  input logic            date_stall,
  input dcc_pkg::date_t  date
);

  // A stalled date transaction holds.
  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    date_valid && date_stall |=> date_valid && $stable(date))
    else $error("date changed or dropped while stalled");

  // The converter is busy right after it takes a timestamp.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && !stamp_stall |=> stamp_stall)
    else $error("timestamp input not stalled after accept");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> date.month >= 4'd1 && date.month <= 4'd12 &&
                   date.day_of_month != 5'd0)
    else $error("month or day of month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> date.hour <= 5'd23 && date.minute <= 6'd59 && date.second <= 6'd59)
    else $error("time of day out of range");

endmodule

bind day_count_to_calendar_date dcc_checker u_dcc_checker (
  .clk         (clk),
  .rst         (rst),
  .stamp_valid (stamp_valid),
  .stamp_stall (stamp_stall),
  .stamp       (stamp),
  .date_valid  (date_valid),
  .date_stall  (date_stall),
  .date        (date)
);
